// File: sv/flc_pkg.sv
// Shared types and constants for the flow cache aggregator.
// Used by flow_cache_aggregator and flc_export; depends on nothing else.
`timescale 1ns / 1ps

package flc_pkg;

	localparam int FLOW_SLOTS_DEF = 32;
	localparam int LIMIT_W        = 6;
	localparam int ADDR_W         = 4;

	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam logic [7:0] FLAG_END_MASK = 8'h05;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 6'd32;
	localparam logic [31:0]        ACTIVE_RESET   = 32'd60000;
	localparam logic [31:0]        INACTIVE_RESET = 32'd10000;

	typedef enum logic [1:0] {
		REG_FLOW_LIMIT = 2'd0,
		REG_ACTIVE     = 2'd1,
		REG_INACTIVE   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [7:0]  service_type;
		logic [7:0]  flags;
		logic [31:0] packets;
		logic [31:0] octets;
		logic [31:0] first_ms;
		logic [31:0] last_ms;
	} flow_rec_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK_REQ,
		ST_WALK,
		ST_POST,
		ST_EVICT,
		ST_NEW,
		ST_ALLOC,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic      push;
		logic      flush;
		flow_rec_t rec;
	} exp_ctrl_t;

	typedef struct packed {
		logic can_push;
		logic pend_v;
	} exp_stat_t;

endpackage

// File: sv/flow_cache_aggregator.sv
// Flow cache aggregator: packet summaries in, exported flow records out.
// Packets arrive on in_valid/in_ready, one word per packet; exported flows leave on
// out_valid/out_ready, one record per word, with last_of_run set on the final
// record that a packet causes. Registers are written over the APB-style port
// (flow_limit at 0x0, active_timeout_ms at 0x4, inactive_timeout_ms at 0x8).
// Flows live in a record RAM and a link RAM; the live flows form a linked list,
// oldest first, and freed slots a stack threaded through the same link RAM.
// Each packet walks the live list at one flow per cycle, limited by the
// registered read of the two RAMs, unless the export stage cannot take a record.
// A packet that matches a flow passes through WALK_REQ, WALK, POST and FLUSH;
// one that opens a flow also through NEW, each eviction through EVICT and POST,
// and the reuse of a freed slot through ALLOC.
// in_ready is high only between packets. An exported record waits in a holding
// register and then in the output register, so a stalled receiver holds the walk
// only once both are full.
// After reset the table is empty, the registers hold their defaults, and slots
// are handed out from a fill count, so no clearing pass is needed.
// Depends on flc_pkg, flc_ram and flc_export.
`timescale 1ns / 1ps

module flow_cache_aggregator #(
	parameter int FLOW_SLOTS = flc_pkg::FLOW_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [flc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [31:0]                src_addr,
	input  logic [31:0]                dst_addr,
	input  logic [15:0]                src_port,
	input  logic [15:0]                dst_port,
	input  logic [7:0]                 protocol,
	input  logic [7:0]                 service_type,
	input  logic [7:0]                 tcp_flag_bits,
	input  logic [15:0]                ip_length,
	input  logic [31:0]                uptime_ms,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [31:0]                out_src_addr,
	output logic [31:0]                out_dst_addr,
	output logic [15:0]                out_src_port,
	output logic [15:0]                out_dst_port,
	output logic [7:0]                 out_protocol,
	output logic [7:0]                 out_service_type,
	output logic [7:0]                 out_flags,
	output logic [31:0]                packet_count,
	output logic [31:0]                octet_count,
	output logic [31:0]                first_ms,
	output logic [31:0]                last_ms,
	output logic                       last_of_run
);

	localparam int IW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
	localparam int CW = $clog2(FLOW_SLOTS + 1);
	localparam int LW = flc_pkg::LIMIT_W;
	localparam logic [LW-1:0] SLOTS_L = LW'(FLOW_SLOTS);

	// Configuration registers.
	logic [LW-1:0] limit_q;
	logic [31:0]   active_q;
	logic [31:0]   inactive_q;
	logic          cfg_we;
	logic [LW-1:0] limit_eff;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= flc_pkg::LIMIT_RESET;
			active_q   <= flc_pkg::ACTIVE_RESET;
			inactive_q <= flc_pkg::INACTIVE_RESET;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				flc_pkg::REG_FLOW_LIMIT: limit_q    <= pwdata[LW-1:0];
				flc_pkg::REG_ACTIVE:     active_q   <= pwdata;
				flc_pkg::REG_INACTIVE:   inactive_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			flc_pkg::REG_FLOW_LIMIT: prdata = 32'(limit_q);
			flc_pkg::REG_ACTIVE:     prdata = active_q;
			flc_pkg::REG_INACTIVE:   prdata = inactive_q;
			default:                 prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (limit_q == '0) begin
			limit_eff = LW'(1);
		end else if (limit_q > SLOTS_L) begin
			limit_eff = SLOTS_L;
		end else begin
			limit_eff = limit_q;
		end
	end

	// Packet held for the duration of its walk.
	flc_pkg::flow_rec_t pkt_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pkt_q.src_addr     <= src_addr;
			pkt_q.dst_addr     <= dst_addr;
			pkt_q.src_port     <= src_port;
			pkt_q.dst_port     <= dst_port;
			pkt_q.protocol     <= protocol;
			pkt_q.service_type <= service_type;
			pkt_q.flags        <= (protocol == flc_pkg::PROTO_TCP) ? tcp_flag_bits : 8'd0;
			pkt_q.packets      <= 32'd1;
			pkt_q.octets       <= 32'(ip_length);
			pkt_q.first_ms     <= uptime_ms;
			pkt_q.last_ms      <= uptime_ms;
		end
	end

	// Stores.
	logic               d_we;
	logic [IW-1:0]      d_waddr;
	flc_pkg::flow_rec_t d_wdata;
	flc_pkg::flow_rec_t d_rdata;
	logic               l_we;
	logic [IW-1:0]      l_waddr;
	logic [IW-1:0]      l_wdata;
	logic [IW-1:0]      l_rdata;
	logic [IW-1:0]      rd_addr;

	flc_ram #(
		.W($bits(flc_pkg::flow_rec_t)),
		.D(FLOW_SLOTS),
		.AW(IW)
	) u_rec_ram (
		.clk(clk),
		.we(d_we),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.raddr(rd_addr),
		.rdata(d_rdata)
	);

	flc_ram #(
		.W(IW),
		.D(FLOW_SLOTS),
		.AW(IW)
	) u_link_ram (
		.clk(clk),
		.we(l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.raddr(rd_addr),
		.rdata(l_rdata)
	);

	// Control state.
	flc_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   rem_q;
	logic [IW-1:0]   head_q;
	logic [IW-1:0]   tail_q;
	logic [IW-1:0]   free_head_q;
	logic [IW-1:0]   cur_q;
	logic [IW-1:0]   prev_q;
	logic            surv_seen_q;
	logic            found_q;

	flc_pkg::exp_ctrl_t exp_ctrl;
	flc_pkg::exp_stat_t exp_stat;
	flc_pkg::flow_rec_t out_rec;

	// Walk datapath on the record just read.
	flc_pkg::flow_rec_t upd;
	logic expired;
	logic key_match;
	logic matched;
	logic walk_export;
	logic new_fin;
	logic stack_empty;

	always_comb begin
		expired = ((pkt_q.last_ms - d_rdata.first_ms) > active_q) ||
			((pkt_q.last_ms - d_rdata.last_ms) > inactive_q);
		key_match = (d_rdata.src_addr == pkt_q.src_addr) &&
			(d_rdata.dst_addr == pkt_q.dst_addr) &&
			(d_rdata.src_port == pkt_q.src_port) &&
			(d_rdata.dst_port == pkt_q.dst_port) &&
			(d_rdata.protocol == pkt_q.protocol);
		upd         = d_rdata;
		upd.packets = d_rdata.packets + 32'd1;
		upd.octets  = d_rdata.octets + pkt_q.octets;
		upd.last_ms = pkt_q.last_ms;
		upd.flags   = d_rdata.flags | pkt_q.flags;
		matched     = !expired && key_match;
		walk_export = expired || (matched && (pkt_q.protocol == flc_pkg::PROTO_TCP) &&
			((upd.flags & flc_pkg::FLAG_END_MASK) != 8'd0));
		new_fin = (pkt_q.protocol == flc_pkg::PROTO_TCP) &&
			((pkt_q.flags & flc_pkg::FLAG_END_MASK) != 8'd0);
		stack_empty = (fill_q == count_q);
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		rd_addr       = cur_q;
		d_we          = 1'b0;
		d_waddr       = cur_q;
		d_wdata       = upd;
		l_we          = 1'b0;
		l_waddr       = cur_q;
		l_wdata       = free_head_q;
		exp_ctrl.push  = 1'b0;
		exp_ctrl.flush = 1'b0;
		exp_ctrl.rec   = expired ? d_rdata : upd;
		unique case (state_q)
			flc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = flc_pkg::ST_WALK_REQ;
				end
			end
			flc_pkg::ST_WALK_REQ: begin
				rd_addr = head_q;
				state_d = (count_q == '0) ? flc_pkg::ST_POST : flc_pkg::ST_WALK;
			end
			flc_pkg::ST_WALK: begin
				exp_ctrl.push = walk_export;
				if (!walk_export || exp_stat.can_push) begin
					if (walk_export) begin
						// Removed flow goes onto the free stack.
						l_we    = 1'b1;
						l_waddr = cur_q;
						l_wdata = free_head_q;
					end else begin
						l_we    = surv_seen_q;
						l_waddr = prev_q;
						l_wdata = cur_q;
						d_we    = matched;
					end
					if (rem_q == CW'(1)) begin
						state_d = flc_pkg::ST_POST;
					end else begin
						rd_addr = l_rdata;
					end
				end
			end
			flc_pkg::ST_POST: begin
				rd_addr = head_q;
				if (found_q) begin
					state_d = flc_pkg::ST_FLUSH;
				end else if (LW'(count_q) >= limit_eff) begin
					state_d = flc_pkg::ST_EVICT;
				end else begin
					state_d = flc_pkg::ST_NEW;
				end
			end
			flc_pkg::ST_EVICT: begin
				rd_addr       = head_q;
				exp_ctrl.push = 1'b1;
				exp_ctrl.rec  = d_rdata;
				if (exp_stat.can_push) begin
					l_we    = 1'b1;
					l_waddr = head_q;
					l_wdata = free_head_q;
					state_d = flc_pkg::ST_POST;
				end
			end
			flc_pkg::ST_NEW: begin
				exp_ctrl.rec = pkt_q;
				d_wdata      = pkt_q;
				if (new_fin) begin
					exp_ctrl.push = 1'b1;
					if (exp_stat.can_push) begin
						state_d = flc_pkg::ST_FLUSH;
					end
				end else if (stack_empty) begin
					d_we    = 1'b1;
					d_waddr = fill_q[IW-1:0];
					l_we    = (count_q != '0);
					l_waddr = tail_q;
					l_wdata = fill_q[IW-1:0];
					state_d = flc_pkg::ST_FLUSH;
				end else begin
					rd_addr = free_head_q;
					state_d = flc_pkg::ST_ALLOC;
				end
			end
			flc_pkg::ST_ALLOC: begin
				d_wdata = pkt_q;
				d_we    = 1'b1;
				d_waddr = free_head_q;
				l_we    = (count_q != '0);
				l_waddr = tail_q;
				l_wdata = free_head_q;
				state_d = flc_pkg::ST_FLUSH;
			end
			flc_pkg::ST_FLUSH: begin
				exp_ctrl.flush = 1'b1;
				if (exp_stat.can_push) begin
					state_d = flc_pkg::ST_IDLE;
				end
			end
			default: state_d = flc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fill_q      <= '0;
			rem_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			surv_seen_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			unique case (state_q)
				flc_pkg::ST_IDLE: begin
					surv_seen_q <= 1'b0;
					found_q     <= 1'b0;
				end
				flc_pkg::ST_WALK_REQ: begin
					cur_q <= head_q;
					rem_q <= count_q;
				end
				flc_pkg::ST_WALK: begin
					if (!walk_export || exp_stat.can_push) begin
						// A matching flow closed by FIN or RST still counts as found.
						if (matched) begin
							found_q <= 1'b1;
						end
						if (walk_export) begin
							free_head_q <= cur_q;
							count_q     <= count_q - CW'(1);
						end else begin
							prev_q      <= cur_q;
							tail_q      <= cur_q;
							surv_seen_q <= 1'b1;
							if (!surv_seen_q) begin
								head_q <= cur_q;
							end
						end
						rem_q <= rem_q - CW'(1);
						cur_q <= l_rdata;
					end
				end
				flc_pkg::ST_EVICT: begin
					if (exp_stat.can_push) begin
						free_head_q <= head_q;
						head_q      <= l_rdata;
						count_q     <= count_q - CW'(1);
					end
				end
				flc_pkg::ST_NEW: begin
					if (!new_fin && stack_empty) begin
						fill_q  <= fill_q + CW'(1);
						count_q <= count_q + CW'(1);
						tail_q  <= fill_q[IW-1:0];
						if (count_q == '0) begin
							head_q <= fill_q[IW-1:0];
						end
					end
				end
				flc_pkg::ST_ALLOC: begin
					free_head_q <= l_rdata;
					count_q     <= count_q + CW'(1);
					tail_q      <= free_head_q;
					if (count_q == '0) begin
						head_q <= free_head_q;
					end
				end
				default: ;
			endcase
		end
	end

	flc_export u_export (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(exp_ctrl),
		.stat(exp_stat),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_rec(out_rec),
		.out_last(last_of_run)
	);

	assign out_src_addr     = out_rec.src_addr;
	assign out_dst_addr     = out_rec.dst_addr;
	assign out_src_port     = out_rec.src_port;
	assign out_dst_port     = out_rec.dst_port;
	assign out_protocol     = out_rec.protocol;
	assign out_service_type = out_rec.service_type;
	assign out_flags        = out_rec.flags;
	assign packet_count     = out_rec.packets;
	assign octet_count      = out_rec.octets;
	assign first_ms         = out_rec.first_ms;
	assign last_ms          = out_rec.last_ms;

	// Every used slot that is not live must sit on the free stack.
	a_fill_covers_count: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= count_q)
		else $error("fill count below live flow count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= FLOW_SLOTS)
		else $error("fill count beyond table size");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flc_pkg::ST_IDLE) |-> !exp_stat.pend_v)
		else $error("record held back while waiting for a packet");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flc_pkg::ST_WALK) |-> (rem_q != '0) && (count_q != '0))
		else $error("walk running with no flows left");

endmodule

// File: sv/flc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the flow record and link stores.
`timescale 1ns / 1ps

module flc_ram #(
	parameter int W  = 8,
	parameter int D  = 32,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/flc_export.sv
// Export stage: holds the newest exported record back by one so that the
// final word of a packet's run can be marked, then drives the output register.
// Depends on flc_pkg.
`timescale 1ns / 1ps

module flc_export (
	input  logic               clk,
	input  logic               arst_n,
	input  flc_pkg::exp_ctrl_t ctrl,
	output flc_pkg::exp_stat_t stat,
	input  logic               out_ready,
	output logic               out_valid,
	output flc_pkg::flow_rec_t out_rec,
	output logic               out_last
);

	logic               pend_v_q;
	flc_pkg::flow_rec_t pend_q;
	logic               out_v_q;
	flc_pkg::flow_rec_t out_rec_q;
	logic               out_last_q;
	logic               out_free;
	logic               do_push;
	logic               do_flush;
	logic               load_out;

	assign out_free      = !out_v_q || out_ready;
	assign stat.can_push = !pend_v_q || out_free;
	assign stat.pend_v   = pend_v_q;
	assign do_push       = ctrl.push && stat.can_push;
	assign do_flush      = ctrl.flush && !ctrl.push && pend_v_q && out_free;
	assign load_out      = (do_push && pend_v_q) || do_flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (do_push) begin
				pend_v_q <= 1'b1;
			end else if (do_flush) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			pend_q <= ctrl.rec;
		end
		if (load_out) begin
			out_rec_q  <= pend_q;
			out_last_q <= do_flush;
		end
	end

	assign out_valid = out_v_q;
	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;

endmodule
